>>> rtl/bdq_pkg.sv
// Shared types and constants of the bounded double-ended queue.
// Used by the controller, the datapath and the top level; no dependencies.
package bdq_pkg;

   // Width of the capacity register and of the command field
   localparam int CAP_W = 11;
   localparam int CMD_W = 3;

   // Defaults of the top-level parameters
   localparam int DEPTH_DEF      = 1024;
   localparam int DATA_WIDTH_DEF = 32;

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   // Command codes; codes above QUERY mean nothing and are refused
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_QUERY      = 3'd4
   } cmd_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic exec;   // accept the request beat and update the pointers
      logic load;   // capture the result into the response register
   } ctl_cmd_type;

endpackage

>>> rtl/bdq_ram.sv
// Generic simple RAM: one write port and two registered read ports.
// No dependencies.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write one entry, read two
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> rtl/bdq_ctrl.sv
// Sequencer of the bounded double-ended queue: request and response handshakes.
// Depends on bdq_pkg.
module bdq_ctrl
   import bdq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ctl_cmd_type ctl_cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The response register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Advance through update, memory read and result capture
   always_comb begin
      state_in     = state_ff;
      ctl_cmd.exec = 1'b0;
      ctl_cmd.load = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl_cmd.exec = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               ctl_cmd.load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response valid until the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl_cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/bdq_dpath.sv
// Datapath of the bounded double-ended queue: ring pointers, count, capacity,
// entry memory and response register. Depends on bdq_pkg and bdq_ram.
module bdq_dpath
   import bdq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctl_cmd_type                  ctl_cmd,
   input  logic [CMD_W-1:0]             req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic                         csr_wr_en,
   input  logic [CAP_W-1:0]             csr_wr_data,
   output logic                         rsp_ok,
   output logic signed [DATA_WIDTH-1:0] rsp_front_value,
   output logic signed [DATA_WIDTH-1:0] rsp_rear_value,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [AW-1:0] LAST_SLOT   = AW'(DEPTH - 1);
   localparam logic [LW-1:0] DEPTH_LIMIT = LW'(DEPTH);

   logic [AW-1:0]    front_ff, front_in;
   logic [AW-1:0]    rear_ff, rear_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CAP_W-1:0] cap_ff;
   logic             ok_ff, ok_in;

   logic             rsp_ok_ff;
   logic [DATA_WIDTH-1:0] rsp_front_ff, rsp_rear_ff;
   logic             rsp_empty_ff, rsp_full_ff;

   logic [AW-1:0]    front_prev, front_next, rear_prev, rear_next;
   logic [LW-1:0]    cap_ext, limit, count_ext;
   logic             has_room, not_empty, is_empty, is_full;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [DATA_WIDTH-1:0] rd_front, rd_rear;

   // Ring neighbors of both ends
   assign front_prev = (front_ff == '0) ? LAST_SLOT : front_ff - AW'(1);
   assign front_next = (front_ff == LAST_SLOT) ? '0 : front_ff + AW'(1);
   assign rear_prev  = (rear_ff == '0) ? LAST_SLOT : rear_ff - AW'(1);
   assign rear_next  = (rear_ff == LAST_SLOT) ? '0 : rear_ff + AW'(1);

   // Clamp the capacity to the memory depth
   assign cap_ext   = LW'(cap_ff);
   assign limit     = (cap_ext > DEPTH_LIMIT) ? DEPTH_LIMIT : cap_ext;
   assign count_ext = LW'(count_ff);
   assign has_room  = count_ext < limit;
   assign not_empty = count_ff != '0;
   assign is_empty  = !not_empty;
   assign is_full   = count_ext >= limit;

   // Decode the command and update pointers, count and memory
   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      count_in = count_ff;
      ok_in    = ok_ff;
      wr_en    = 1'b0;
      wr_addr  = rear_ff;
      if (ctl_cmd.exec) begin
         ok_in = 1'b0;
         unique case (req_cmd)
            CMD_PUSH_FRONT: begin
               if (has_room) begin
                  front_in = front_prev;
                  wr_en    = 1'b1;
                  wr_addr  = front_prev;
                  count_in = count_ff + CW'(1);
                  ok_in    = 1'b1;
               end
            end
            CMD_PUSH_BACK: begin
               if (has_room) begin
                  rear_in  = rear_next;
                  wr_en    = 1'b1;
                  wr_addr  = rear_ff;
                  count_in = count_ff + CW'(1);
                  ok_in    = 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (not_empty) begin
                  front_in = front_next;
                  count_in = count_ff - CW'(1);
                  ok_in    = 1'b1;
               end
            end
            CMD_POP_BACK: begin
               if (not_empty) begin
                  rear_in  = rear_prev;
                  count_in = count_ff - CW'(1);
                  ok_in    = 1'b1;
               end
            end
            CMD_QUERY: begin
               ok_in = 1'b1;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
         ok_ff    <= 1'b0;
      end else begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
         ok_ff    <= ok_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // Entry memory: read the front slot and the slot before the rear
   bdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_value),
      .rd_addr_a (front_ff),
      .rd_data_a (rd_front),
      .rd_addr_b (rear_prev),
      .rd_data_b (rd_rear)
   );

   // Capture the response beat; an empty queue reports all ones
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_front_ff <= is_empty ? '1 : rd_front;
         rsp_rear_ff  <= is_empty ? '1 : rd_rear;
         rsp_empty_ff <= is_empty;
         rsp_full_ff  <= is_full;
      end
   end

   assign rsp_ok          = rsp_ok_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_rear_value  = rsp_rear_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

endmodule

>>> rtl/bounded_double_ended_queue_top.sv
// Bounded double-ended queue held in a ring buffer of DEPTH entries. Each request
// beat carries one command (push front, push back, pop front, pop back, query) and
// yields one response beat with the success flag, the front and rear entries (all
// ones when empty) and the empty and full flags after the command. The capacity
// register is clamped to DEPTH. A command goes from acceptance to a captured result
// through pointer and count update with the memory write, then the registered read
// of the entry memory, then capture into the response register once that register
// is free; no new command is accepted until the result has been captured.
// Depends on bdq_pkg, bdq_ctrl, bdq_dpath and bdq_ram.
module bounded_double_ended_queue_top
   import bdq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [CMD_W-1:0]             req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_ok,
   output logic signed [DATA_WIDTH-1:0] rsp_front_value,
   output logic signed [DATA_WIDTH-1:0] rsp_rear_value,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full,
   input  logic                         csr_wr_en,
   input  logic [CAP_W-1:0]             csr_wr_data
);

   ctl_cmd_type ctl_cmd;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl_cmd   (ctl_cmd)
   );

   bdq_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl_cmd         (ctl_cmd),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ok          (rsp_ok),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

   // An accepted beat keeps the sequencer busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // An empty queue reports all ones at both ends
   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_front_value == '1) && (rsp_rear_value == '1))
      else $error("empty response carries data");

   // A new response only follows a command in flight
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without a command in flight");

endmodule
